// ----- rtl/lpd_pkg.sv -----
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types, codes and the CRC-8 step for the lidar packet deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam logic [7:0]  START_BYTE  = 8'h54;
  localparam logic [7:0]  DATA_FRAME  = 8'h2c;
  localparam logic [15:0] ANGLE_MOD   = 16'd36000;
  localparam logic [10:0] COUNT_MAX   = 11'd2047;
  localparam int          STORE_DEPTH = 47;

  // Configuration register indexes
  localparam logic [1:0] REG_CRC_POLY  = 2'd0;
  localparam logic [1:0] REG_CAL_PKTS  = 2'd1;
  localparam logic [1:0] REG_TS_WRAP   = 2'd2;

  // Parser phase
  typedef enum logic [2:0] {
    PH_HUNT  = 3'b001,
    PH_FRAME = 3'b010,
    PH_BODY  = 3'b100
  } phase_t;

  // Packet finish sequencer
  typedef enum logic [10:0] {
    ST_IDLE = 11'b00000000001,
    ST_RTS0 = 11'b00000000010,
    ST_RTS1 = 11'b00000000100,
    ST_UPD  = 11'b00000001000,
    ST_MUL  = 11'b00000010000,
    ST_CONT = 11'b00000100000,
    ST_DIV  = 11'b00001000000,
    ST_HDR  = 11'b00010000000,
    ST_MOD  = 11'b00100000000,
    ST_PT   = 11'b01000000000,
    ST_OUT  = 11'b10000000000
  } seq_t;

  // Divider request
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [9:0]  divisor;
  } div_req_t;

  // One CRC-8 byte step, MSB first
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b,
                                          input logic [7:0] poly);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ poly) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

endpackage

// ----- rtl/lidar_packet_deframer_top.sv -----
// ----------------------------------------------------------------------------
// lidar_packet_deframer_top
// Serial byte deframer, CRC-8 check and point decoder for a scanning lidar.
// ----------------------------------------------------------------------------
// Each byte of a packet is written into a 47-byte packet RAM while the CRC
// runs. A good data packet then holds off input while a sequencer reads the
// timestamp back (ST_RTS0, ST_RTS1) and unwraps it (ST_UPD, ST_MUL, ST_CONT);
// during calibration it accumulates the host offset and returns to idle.
// After calibration a serial divider forms the averaged offset, six header
// bytes are read, the angles are reduced below 36000, and each point is read
// from RAM in ST_PT and held in ST_OUT until the result side takes it. The
// single RAM read port sets the per-point cost.
// Register writes are taken at any time.
module lidar_packet_deframer_top #(
  parameter int POINTS_PER_PACKET    = 12,
  parameter int DATA_PACKET_BYTES    = 47,
  parameter int COMMAND_PACKET_BYTES = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: rx_byte[7:0], host_time_ms[38:8], zero pad [39]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,
  // out_tdata: point_index[3:0], distance_mm[19:4], intensity[27:20],
  // speed_deg_s[43:28], first_angle_cdeg[59:44], last_angle_cdeg[75:60],
  // time_ms[107:76], zero pad [111:108]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [16:0]  cfg_data
);

  import lpd_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [AW-1:0] TS_LO   = AW'(DATA_PACKET_BYTES - 3);
  localparam logic [AW-1:0] TS_HI   = AW'(DATA_PACKET_BYTES - 2);
  localparam logic [AW-1:0] EA_LO   = AW'(DATA_PACKET_BYTES - 5);
  localparam logic [AW-1:0] EA_HI   = AW'(DATA_PACKET_BYTES - 4);
  localparam logic [AW-1:0] LEN_DAT = AW'(DATA_PACKET_BYTES);
  localparam logic [AW-1:0] LEN_CMD = AW'(COMMAND_PACKET_BYTES);
  localparam logic [3:0]    LAST_PT = 4'(POINTS_PER_PACKET - 1);

  // Configuration registers
  logic [7:0]  crc_poly_r;
  logic [9:0]  cal_pkts_r;
  logic [16:0] ts_wrap_r;

  // Parser state
  phase_t      phase_r;
  logic [AW-1:0] pos_r;
  logic        is_data_r;
  logic [7:0]  crc_r;

  // Packet state
  logic [15:0] prev_ts_r;
  logic [31:0] wrap_r;
  logic [10:0] good_r;
  logic [31:0] offset_r;

  // Sequencer
  seq_t        seq_r, seq_nxt;
  logic [30:0] host_r;
  logic [7:0]  ts_lo_r;
  logic [15:0] ts_r;
  logic [31:0] mul_r;
  logic [31:0] cont_r;
  logic [31:0] tm_r;
  logic [2:0]  k_r;
  logic [7:0]  hdr_r [6];
  logic [15:0] speed_r, sa_r, ea_r;
  logic [1:0]  j_r;
  logic [AW-1:0] base_r;
  logic [3:0]  pt_r;
  logic [7:0]  dlo_r, dhi_r, inten_r;

  // RAM
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  // Divider
  div_req_t    dreq;
  logic        ddone;
  logic [31:0] dquot;

  logic [7:0]  rx;
  logic [AW-1:0] len;
  logic        in_acc;
  logic [15:0] ts_now;
  logic [48:0] prod;
  logic [31:0] cont_now;
  logic [31:0] avg;

  assign rx        = in_tdata[7:0];
  assign in_tready = (seq_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign len       = is_data_r ? LEN_DAT : LEN_CMD;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_poly_r <= 8'd77;
      cal_pkts_r <= 10'd100;
      ts_wrap_r  <= 17'd30000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CRC_POLY: crc_poly_r <= cfg_data[7:0];
        REG_CAL_PKTS: cal_pkts_r <= cfg_data[9:0];
        REG_TS_WRAP:  ts_wrap_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Store each packet byte at its packet position
  always_comb begin
    we    = 1'b0;
    waddr = pos_r;
    wdata = rx;
    if (in_acc) begin
      unique case (phase_r)
        PH_FRAME: begin
          we    = 1'b1;
          waddr = AW'(1);
        end
        PH_BODY: we = 1'b1;
        default: begin
          we    = (rx == START_BYTE);
          waddr = '0;
        end
      endcase
    end
  end

  // Parse bytes: hunt, frame, body
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      pos_r     <= '0;
      is_data_r <= 1'b0;
      crc_r     <= '0;
    end else if (in_acc) begin
      unique case (phase_r)
        PH_FRAME: begin
          is_data_r <= (rx == DATA_FRAME);
          crc_r     <= crc_step(crc_r, rx, crc_poly_r);
          pos_r     <= AW'(2);
          phase_r   <= PH_BODY;
        end
        PH_BODY: begin
          if (pos_r + AW'(1) < len) begin
            crc_r <= crc_step(crc_r, rx, crc_poly_r);
            pos_r <= pos_r + AW'(1);
          end else begin
            phase_r <= PH_HUNT;
            pos_r   <= '0;
          end
        end
        default: begin
          if (rx == START_BYTE) begin
            crc_r   <= crc_step(8'd0, rx, crc_poly_r);
            pos_r   <= AW'(1);
            phase_r <= PH_FRAME;
          end else begin
            phase_r <= PH_HUNT;
          end
        end
      endcase
    end
  end

  lpd_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Select the read address for the sequencer
  always_comb begin
    raddr = TS_LO;
    unique case (seq_r)
      ST_RTS1: raddr = TS_HI;
      ST_HDR: begin
        unique case (k_r)
          3'd0:    raddr = AW'(2);
          3'd1:    raddr = AW'(3);
          3'd2:    raddr = AW'(4);
          3'd3:    raddr = AW'(5);
          3'd4:    raddr = EA_LO;
          default: raddr = EA_HI;
        endcase
      end
      ST_PT:   raddr = base_r + AW'(j_r);
      default: raddr = TS_LO;
    endcase
  end

  assign ts_now   = {rdata, ts_lo_r};
  assign prod     = 49'(wrap_r) * 49'(ts_wrap_r);
  assign cont_now = mul_r + {16'd0, ts_r};
  assign avg      = (cal_pkts_r == 10'd0) ? 32'd0 :
                    (offset_r[31] ? (32'd0 - dquot) : dquot);

  always_comb begin
    dreq.start    = (seq_r == ST_CONT) && (good_r > {1'b0, cal_pkts_r});
    dreq.dividend = offset_r[31] ? (32'd0 - offset_r) : offset_r;
    dreq.divisor  = cal_pkts_r;
  end

  lpd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (dreq),
    .done     (ddone),
    .quotient (dquot)
  );

  // Advance the finish sequencer
  always_comb begin
    seq_nxt = seq_r;
    unique case (seq_r)
      ST_IDLE: begin
        if (in_acc && phase_r == PH_BODY && !(pos_r + AW'(1) < len)
            && is_data_r && crc_r == rx) begin
          seq_nxt = ST_RTS0;
        end
      end
      ST_RTS0: seq_nxt = ST_RTS1;
      ST_RTS1: seq_nxt = ST_UPD;
      ST_UPD:  seq_nxt = ST_MUL;
      ST_MUL:  seq_nxt = ST_CONT;
      ST_CONT: seq_nxt = dreq.start ? ST_DIV : ST_IDLE;
      ST_DIV:  seq_nxt = ddone ? ST_HDR : ST_DIV;
      ST_HDR:  seq_nxt = (k_r == 3'd6) ? ST_MOD : ST_HDR;
      ST_MOD:  seq_nxt = ST_PT;
      ST_PT:   seq_nxt = (j_r == 2'd3) ? ST_OUT : ST_PT;
      ST_OUT: begin
        if (out_tready) begin
          seq_nxt = (pt_r == LAST_PT) ? ST_IDLE : ST_PT;
        end
      end
      default: seq_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r     <= ST_IDLE;
      prev_ts_r <= '0;
      wrap_r    <= '0;
      good_r    <= '0;
      offset_r  <= '0;
      k_r       <= '0;
      j_r       <= '0;
      pt_r      <= '0;
    end else begin
      seq_r <= seq_nxt;
      unique case (seq_r)
        ST_IDLE: host_r <= in_tdata[38:8];
        ST_RTS1: ts_lo_r <= rdata;
        ST_UPD: begin
          ts_r      <= ts_now;
          prev_ts_r <= ts_now;
          if (prev_ts_r > ts_now) begin
            wrap_r <= wrap_r + 32'd1;
          end
          if (good_r < COUNT_MAX) begin
            good_r <= good_r + 11'd1;
          end
        end
        ST_MUL: mul_r <= prod[31:0];
        ST_CONT: begin
          cont_r <= cont_now;
          k_r    <= '0;
          if (!dreq.start) begin
            offset_r <= offset_r + ({1'b0, host_r} - cont_now);
          end
        end
        ST_DIV: tm_r <= cont_r + avg;
        ST_HDR: begin
          if (k_r != 3'd0) begin
            hdr_r[k_r - 3'd1] <= rdata;
          end
          k_r <= k_r + 3'd1;
        end
        ST_MOD: begin
          speed_r <= {hdr_r[1], hdr_r[0]};
          sa_r    <= ({hdr_r[3], hdr_r[2]} >= ANGLE_MOD) ?
                     {hdr_r[3], hdr_r[2]} - ANGLE_MOD : {hdr_r[3], hdr_r[2]};
          ea_r    <= ({hdr_r[5], hdr_r[4]} >= ANGLE_MOD) ?
                     {hdr_r[5], hdr_r[4]} - ANGLE_MOD : {hdr_r[5], hdr_r[4]};
          base_r  <= AW'(6);
          pt_r    <= '0;
          j_r     <= '0;
        end
        ST_PT: begin
          unique case (j_r)
            2'd1:    dlo_r   <= rdata;
            2'd2:    dhi_r   <= rdata;
            2'd3:    inten_r <= rdata;
            default: ;
          endcase
          j_r <= j_r + 2'd1;
        end
        ST_OUT: begin
          if (out_tready) begin
            pt_r   <= pt_r + 4'd1;
            base_r <= base_r + AW'(3);
            j_r    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Drive the point result from the output registers
  assign out_tvalid = (seq_r == ST_OUT);
  assign out_tlast  = (pt_r == LAST_PT);
  assign out_tdata  = {4'd0, tm_r, ea_r, sa_r, speed_r, inten_r, dhi_r, dlo_r, pt_r};

  // Input and output never both open
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a point is pending");

  // Last flag only on the final point index
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[3:0] == LAST_PT)
    else $error("last flag on wrong point");

  // A stalled point keeps its index
  a_hold_pt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(pt_r))
    else $error("point index moved under stall");

  // Divider finishes only while the sequencer waits for it
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ddone |-> seq_r == ST_DIV)
    else $error("divider done outside its wait state");

endmodule

// ----- rtl/lpd_ram.sv -----
// ----------------------------------------------------------------------------
// lpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 47,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/lpd_div.sv -----
// ----------------------------------------------------------------------------
// lpd_div
// Restoring unsigned divider, one quotient bit per cycle (32 by 10 bits).
// ----------------------------------------------------------------------------
module lpd_div (
  input  logic             clk,
  input  logic             rst_n,
  input  lpd_pkg::div_req_t req,
  output logic             done,
  output logic [31:0]      quotient
);

  logic [31:0] q_r, q_nxt;
  logic [10:0] rem_r, rem_nxt;
  logic [9:0]  dvs_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [10:0] rem_sh;

  // Load a new request, or shift in one dividend bit and try a subtract
  always_comb begin
    rem_sh   = {rem_r[9:0], q_r[31]};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (req.start) begin
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      dvs_r <= req.divisor;
    end
  end

  assign done     = busy_r && (cnt_r == 6'd31);
  assign quotient = q_nxt;

endmodule
